// ===== rtl/core/pva_pkg.sv =====
// Package with the shared types, constants and codes of the voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

  // Sizes of the allocator.
  localparam int VOICE_COUNT = 8;
  localparam int LIST_DEPTH  = 16;
  localparam int MASK_W      = 8;
  localparam int VOICE_W     = 3;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int ACTION_W    = 2;
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  // Only voices below both the voice count and the mask width can be free.
  localparam int MASK_LIMIT  = (VOICE_COUNT < MASK_W) ? VOICE_COUNT : MASK_W;

  // Event kinds.
  localparam logic FUNC_ON  = 1'b0;
  localparam logic FUNC_OFF = 1'b1;

  // Result actions.
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  // Input word: one note event.
  typedef struct packed {
    logic              func;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [MASK_W-1:0] released_mask;
  } event_t;

  // Output word: one voice action.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VOICE_W-1:0]  voice;
    logic [NOTE_W-1:0]   note_out;
    logic [VEL_W-1:0]    velocity_out;
    logic                overflow;
  } result_t;

  // One list entry held in a cell.
  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [NOTE_W-1:0]  note;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/pva_cell.sv =====
// One cell of the entry chain: holds one entry, shifts toward the head or loads.
`timescale 1ns / 1ps

module pva_cell (
  input  logic              clk,
  input  pva_pkg::cell_ctl_t ctl,
  input  pva_pkg::entry_t   load_data,
  input  pva_pkg::entry_t   nbr,
  output pva_pkg::entry_t   q
);

  // A load wins over the shift from the neighbor.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= load_data;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule

// ===== rtl/core/poly_voice_allocator.sv =====
// Top level of the voice allocator: entry chain, walk sequencer and result register.
//
// Usage: note events enter on the event channel (event_valid, event_stall,
// event_word) and one allocation word per event leaves on the alloc channel
// (alloc_valid, alloc_stall, alloc_word). The list of voice and note entries
// sits in a chain of cells, oldest at the head. For each event the chain is
// rotated once through its valid entries, one entry per cycle; the head is
// compared with the note, a matching entry is dropped on note off, the oldest
// entry is dropped on a note on into a full list, and every other entry is
// pushed back at the tail. A note on then appends its entry. After the walk
// in ST_WALK the result is formed in ST_FINISH and loaded into the result
// register. One event is worked on at a time, so a new event is taken only
// once the last one has left ST_FINISH. The result register lets the next
// event be accepted while a result still waits. A stalled result holds, and
// a finished event waits for the register to free up.
// Reset empties the list at once; entry contents are not cleared.
`timescale 1ns / 1ps

module poly_voice_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             event_valid,
  output logic             event_stall,
  input  pva_pkg::event_t  event_word,
  output logic             alloc_valid,
  input  logic             alloc_stall,
  output pva_pkg::result_t alloc_word
);

  pva_pkg::state_t state, state_next;
  logic [pva_pkg::CNT_W-1:0] count, count_next;
  logic [pva_pkg::CNT_W-1:0] steps, steps_next;
  logic [pva_pkg::CNT_W-1:0] idx, idx_next;
  pva_pkg::event_t req, req_next;
  logic found, found_next;
  logic ovf, ovf_next;
  logic free_found, free_found_next;
  logic [pva_pkg::VOICE_W-1:0] free_voice, free_voice_next;
  logic [pva_pkg::VOICE_W-1:0] match_voice, match_voice_next;
  logic [pva_pkg::VOICE_W-1:0] oldest_voice, oldest_voice_next;
  pva_pkg::result_t result_next;
  logic finish_go;

  logic chain_shift;
  logic ld_en;
  logic [pva_pkg::IDX_W-1:0] ld_idx;
  pva_pkg::entry_t ld_data;
  pva_pkg::entry_t head;
  logic hit;
  logic discard;
  logic [pva_pkg::VOICE_W-1:0] on_voice;

  pva_pkg::entry_t   cell_q   [pva_pkg::LIST_DEPTH];
  pva_pkg::cell_ctl_t cell_ctl [pva_pkg::LIST_DEPTH];

  // Chain of cells; each takes its neighbor toward the tail on a shift.
  for (genvar k = 0; k < pva_pkg::LIST_DEPTH; k++) begin : g_cell
    pva_pkg::entry_t nbr;
    if (k == pva_pkg::LIST_DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = cell_q[k+1];
    end
    assign cell_ctl[k].shift = chain_shift;
    assign cell_ctl[k].load  = ld_en && (ld_idx == pva_pkg::IDX_W'(k));
    pva_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[k]),
      .load_data (ld_data),
      .nbr       (nbr),
      .q         (cell_q[k])
    );
  end

  assign head = cell_q[0];

  // Walk decisions at the head of the chain.
  assign hit     = !found && (head.note == req.note);
  assign discard = (hit && (req.func == pva_pkg::FUNC_OFF)) ||
                   (ovf && (idx == '0));

  // Voice chosen for a note on once the walk is done.
  assign on_voice = found      ? match_voice :
                    free_found ? free_voice  :
                    (steps != '0) ? oldest_voice : '0;

  // Sequencer: next state, chain control and the result.
  always_comb begin
    state_next        = state;
    count_next        = count;
    steps_next        = steps;
    idx_next          = idx;
    req_next          = req;
    found_next        = found;
    ovf_next          = ovf;
    free_found_next   = free_found;
    free_voice_next   = free_voice;
    match_voice_next  = match_voice;
    oldest_voice_next = oldest_voice;
    result_next       = '0;
    finish_go         = 1'b0;
    chain_shift       = 1'b0;
    ld_en             = 1'b0;
    ld_idx            = '0;
    ld_data           = head;
    event_stall       = (state != pva_pkg::ST_IDLE);

    unique case (state)
      pva_pkg::ST_IDLE: begin
        if (event_valid) begin
          req_next        = event_word;
          steps_next      = count;
          idx_next        = '0;
          found_next      = 1'b0;
          ovf_next        = (event_word.func == pva_pkg::FUNC_ON) &&
                            (count == pva_pkg::CNT_W'(pva_pkg::LIST_DEPTH));
          free_found_next = 1'b0;
          free_voice_next = '0;
          // Lowest released voice.
          for (int i = pva_pkg::MASK_LIMIT - 1; i >= 0; i--) begin
            if (event_word.released_mask[i]) begin
              free_found_next = 1'b1;
              free_voice_next = pva_pkg::VOICE_W'(i);
            end
          end
          state_next = pva_pkg::ST_WALK;
        end
      end

      pva_pkg::ST_WALK: begin
        if (idx == steps) begin
          state_next = pva_pkg::ST_FINISH;
        end else begin
          // Pop the head; push it back at the tail unless it is dropped.
          chain_shift = 1'b1;
          ld_data     = head;
          ld_idx      = pva_pkg::IDX_W'(count - pva_pkg::CNT_W'(1));
          ld_en       = !discard;
          if (discard) begin
            count_next = count - pva_pkg::CNT_W'(1);
          end
          if (idx == '0) begin
            oldest_voice_next = head.voice;
          end
          if (hit) begin
            found_next       = 1'b1;
            match_voice_next = head.voice;
          end
          idx_next = idx + pva_pkg::CNT_W'(1);
        end
      end

      pva_pkg::ST_FINISH: begin
        if (req.func == pva_pkg::FUNC_ON) begin
          result_next.action       = pva_pkg::ACT_START;
          result_next.voice        = on_voice;
          result_next.note_out     = req.note;
          result_next.velocity_out = req.velocity;
          result_next.overflow     = ovf;
        end else if (found) begin
          result_next.action   = pva_pkg::ACT_RELEASE;
          result_next.voice    = match_voice;
          result_next.note_out = req.note;
        end
        if (!alloc_valid || !alloc_stall) begin
          finish_go  = 1'b1;
          state_next = pva_pkg::ST_IDLE;
          // Append the new entry at the tail on note on.
          if (req.func == pva_pkg::FUNC_ON) begin
            ld_en         = 1'b1;
            ld_idx        = pva_pkg::IDX_W'(count);
            ld_data.voice = on_voice;
            ld_data.note  = req.note;
            count_next    = count + pva_pkg::CNT_W'(1);
          end
        end
      end

      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pva_pkg::ST_IDLE;
      count       <= '0;
      alloc_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (finish_go) begin
        alloc_valid <= 1'b1;
      end else if (!alloc_stall) begin
        alloc_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current event and the result word.
  always_ff @(posedge clk) begin
    steps        <= steps_next;
    idx          <= idx_next;
    req          <= req_next;
    found        <= found_next;
    ovf          <= ovf_next;
    free_found   <= free_found_next;
    free_voice   <= free_voice_next;
    match_voice  <= match_voice_next;
    oldest_voice <= oldest_voice_next;
    if (finish_go) begin
      alloc_word <= result_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted event keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_stall |=> event_stall)
    else $error("event accepted but input not stalled afterwards");

  // Overflow is only reported together with a voice start.
  a_ovf_on_start: assert property (@(posedge clk) disable iff (rst)
    alloc_valid && alloc_word.overflow |-> alloc_word.action == pva_pkg::ACT_START)
    else $error("overflow flagged on a result that is not a start");

  // An empty result carries no voice or note.
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    alloc_valid && (alloc_word.action == pva_pkg::ACT_NONE) |->
      (alloc_word.voice == '0) && (alloc_word.note_out == '0))
    else $error("empty result with nonzero fields");

  // The list never grows past its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    finish_go |=> count <= pva_pkg::CNT_W'(pva_pkg::LIST_DEPTH))
    else $error("entry count beyond list depth");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the voice allocator: directed cases, list overflow, back-pressure and random traffic.
`timescale 1ns / 1ps

module tb_top;
  import pva_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int BLOCK_ITEMS  = 100;

  logic    clk = 1'b0;
  logic    rst;
  logic    event_valid;
  logic    event_stall;
  event_t  event_word;
  logic    alloc_valid;
  logic    alloc_stall;
  result_t alloc_word;

  // Predicted list of held voices, oldest first, and the words still due.
  entry_t  held_notes[$];
  result_t pending_allocs[$];
  result_t want;

  bit idle_en;
  int hold_left;
  int stall_run;
  int errors;
  int cycle_count;
  int n_sent;
  int n_start;
  int n_release;
  int n_none;
  int n_overflow;

  poly_voice_allocator i_dut (
    .clk        (clk),
    .rst        (rst),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_word (event_word),
    .alloc_valid(alloc_valid),
    .alloc_stall(alloc_stall),
    .alloc_word (alloc_word)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length of one idle stretch: mostly short, now and then long.
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(12, 50);
  endfunction

  // Works out the allocation word for one accepted event and updates the held list.
  function automatic result_t predict_alloc(event_t ev);
    result_t            r;
    int                 pos;
    bit                 found;
    logic [VOICE_W-1:0] v;
    r     = '0;
    pos   = -1;
    found = 1'b0;
    v     = '0;
    foreach (held_notes[i]) begin
      if (pos < 0 && held_notes[i].note == ev.note) pos = i;
    end
    // A note off releases the oldest entry with that note, if there is one.
    if (ev.func == FUNC_OFF) begin
      if (pos >= 0) begin
        r.action   = ACT_RELEASE;
        r.voice    = held_notes[pos].voice;
        r.note_out = ev.note;
        held_notes.delete(pos);
      end
      return r;
    end
    // Same note reuses its voice; else lowest released voice; else steal the oldest.
    if (pos >= 0) begin
      v = held_notes[pos].voice;
    end else begin
      for (int i = 0; i < MASK_LIMIT; i++) begin
        if (!found && ev.released_mask[i]) begin
          v     = VOICE_W'(i);
          found = 1'b1;
        end
      end
      if (!found) v = (held_notes.size() > 0) ? held_notes[0].voice : '0;
    end
    if (held_notes.size() >= LIST_DEPTH) begin
      void'(held_notes.pop_front());
      r.overflow = 1'b1;
    end
    held_notes.insert(held_notes.size(), entry_t'{voice: v, note: ev.note});
    r.action       = ACT_START;
    r.voice        = v;
    r.note_out     = ev.note;
    r.velocity_out = ev.velocity;
    return r;
  endfunction

  function automatic event_t mk_event(logic func, logic [NOTE_W-1:0] note,
                                      logic [VEL_W-1:0] vel, logic [MASK_W-1:0] mask);
    event_t ev;
    ev.func          = func;
    ev.note          = note;
    ev.velocity      = vel;
    ev.released_mask = mask;
    return ev;
  endfunction

  // Random event: note ons mostly from a narrow pool so notes repeat, note offs
  // mostly aimed at notes that are held.
  function automatic event_t random_event(int pool_base, int off_pct);
    event_t ev;
    int     m;
    ev.velocity = VEL_W'($urandom_range(0, 127));
    m = $urandom_range(0, 99);
    if (m < 35) begin
      ev.released_mask = '0;
    end else if (m < 65) begin
      ev.released_mask = MASK_W'(1 << $urandom_range(0, MASK_W - 1));
    end else begin
      ev.released_mask = MASK_W'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < off_pct) begin
      ev.func = FUNC_OFF;
      if (held_notes.size() > 0 && $urandom_range(0, 99) < 80) begin
        ev.note = held_notes[$urandom_range(0, held_notes.size() - 1)].note;
      end else begin
        ev.note = NOTE_W'($urandom_range(0, 127));
      end
    end else begin
      ev.func = FUNC_ON;
      if ($urandom_range(0, 99) < 80) begin
        ev.note = NOTE_W'(pool_base + $urandom_range(0, 23));
      end else begin
        ev.note = NOTE_W'($urandom_range(0, 127));
      end
    end
    return ev;
  endfunction

  // Offers one event word, with an optional gap first, and waits until it is taken.
  task automatic send_event(input event_t ev);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 99) < 35) begin
      event_valid = 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    event_word  = ev;
    event_valid = 1'b1;
    do @(posedge clk); while (event_stall);
    pending_allocs.insert(pending_allocs.size(), predict_alloc(ev));
    n_sent++;
  endtask

  // Stops offering and waits until every predicted word has come out.
  task automatic drain_allocs();
    @(negedge clk);
    event_valid = 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 4) @(posedge clk);
  endtask

  // Receiver: a forced hold-off first, else random stall stretches.
  always @(negedge clk) begin
    if (rst) begin
      alloc_stall = 1'b0;
      stall_run   = 0;
    end else if (hold_left > 0) begin
      alloc_stall = 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      alloc_stall = 1'b1;
      stall_run--;
    end else begin
      alloc_stall = 1'b0;
      if (idle_en && $urandom_range(0, 99) < 30) stall_run = gap_len();
    end
  end

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
    end
  endtask

  // Compares each accepted allocation word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && alloc_valid && !alloc_stall) begin
      if (pending_allocs.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word, expected none, actual %p", $time, alloc_word);
      end else begin
        want = pending_allocs.pop_front();
        check_field("action", 8'(want.action), 8'(alloc_word.action));
        check_field("voice", 8'(want.voice), 8'(alloc_word.voice));
        check_field("note_out", 8'(want.note_out), 8'(alloc_word.note_out));
        check_field("velocity_out", 8'(want.velocity_out), 8'(alloc_word.velocity_out));
        check_field("overflow", 8'(want.overflow), 8'(alloc_word.overflow));
        case (want.action)
          ACT_START:   n_start++;
          ACT_RELEASE: n_release++;
          default:     n_none++;
        endcase
        if (want.overflow) n_overflow++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, pending_allocs.size());
      $display("poly_voice_allocator test failed");
      $finish;
    end
  end

  // Empty list, every way of choosing a voice, duplicates and unmatched note offs.
  task automatic test_directed_cases();
    send_event(mk_event(FUNC_OFF, 7'd127, 7'd127, 8'hff));  // nothing held yet
    send_event(mk_event(FUNC_ON, 7'd0, 7'd0, 8'h00));       // empty list, nothing free
    send_event(mk_event(FUNC_ON, 7'd127, 7'd127, 8'h00));   // steal the oldest voice
    send_event(mk_event(FUNC_ON, 7'd60, 7'd64, 8'h80));     // top voice released
    send_event(mk_event(FUNC_ON, 7'd61, 7'd1, 8'hff));      // lowest released voice wins
    send_event(mk_event(FUNC_ON, 7'd60, 7'd100, 8'h04));    // held note keeps its voice
    send_event(mk_event(FUNC_OFF, 7'd60, 7'd127, 8'h00));   // oldest duplicate goes first
    send_event(mk_event(FUNC_OFF, 7'd60, 7'd55, 8'hff));
    send_event(mk_event(FUNC_OFF, 7'd60, 7'd0, 8'h00));     // no match left
    drain_allocs();
  endtask

  // Fills the list past its depth so the oldest entry is dropped.
  task automatic test_list_overflow();
    for (int i = 0; i < 14; i++) begin
      send_event(mk_event(FUNC_ON, NOTE_W'(20 + i), VEL_W'(i * 9),
                          (i % 3 == 0) ? 8'h00 : MASK_W'(1 << (i % MASK_W))));
    end
    send_event(mk_event(FUNC_OFF, 7'd0, 7'd3, 8'h00));      // dropped on overflow
    send_event(mk_event(FUNC_OFF, 7'd127, 7'd3, 8'h00));
    drain_allocs();
  endtask

  // Receiver holds off for a long stretch while events keep coming.
  task automatic test_backpressure();
    idle_en = 1'b0;
    @(posedge clk);
    hold_left = 150;
    repeat (12) send_event(random_event($urandom_range(0, 104), 30));
    drain_allocs();
    idle_en = 1'b1;
  endtask

  // Blocks of random traffic, each with its own note pool, note-off share and idling.
  task automatic test_random_traffic();
    int pool_base;
    int off_pct;
    for (int b = 0; b < RANDOM_ITEMS / BLOCK_ITEMS; b++) begin
      pool_base = $urandom_range(0, 104);
      case ($urandom_range(0, 2))
        0:       off_pct = 15;
        1:       off_pct = 40;
        default: off_pct = 55;
      endcase
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (BLOCK_ITEMS) send_event(random_event(pool_base, off_pct));
    end
    idle_en = 1'b1;
    drain_allocs();
  endtask

  initial begin
    rst         = 1'b1;
    event_valid = 1'b0;
    event_word  = '0;
    alloc_stall = 1'b0;
    idle_en     = 1'b1;
    hold_left   = 0;
    stall_run   = 0;
    errors      = 0;
    cycle_count = 0;
    n_sent      = 0;
    n_start     = 0;
    n_release   = 0;
    n_none      = 0;
    n_overflow  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_list_overflow();
    test_backpressure();
    test_random_traffic();

    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (pending_allocs.size() != 0) begin
      errors++;
      $display("%0t ns: %0d predicted words never arrived", $time, pending_allocs.size());
    end
    $display("Sent %0d note events; checked %0d voice starts, %0d releases, %0d no-ops.",
             n_sent, n_start, n_release, n_none);
    $display("List overflowed %0d times; %0d mismatches seen.", n_overflow, errors);
    if (errors == 0) begin
      $display("poly_voice_allocator test passed");
    end else begin
      $display("poly_voice_allocator test failed");
    end
    $finish;
  end

endmodule
